FILE: design/rcp_pkg.sv
package rcp_pkg;

    localparam int MAX_WIDTH  = 256;
    localparam int MAX_HEIGHT = 256;

    localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int ROW_W = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

    // Wide enough for any canvas size up to 4096 and any cell index.
    localparam int IDX_W = 13;

    // Coordinates in Q15.8 with room for the sums of origin and size.
    localparam int FIX_W = 24;
    localparam int CMP_W = 27;
    localparam logic signed [CMP_W-1:0] ONE_UNIT = CMP_W'(256);

    localparam logic [1:0] FUNC_DRAW  = 2'd0;
    localparam logic [1:0] FUNC_READ  = 2'd1;
    localparam logic [1:0] FUNC_CLEAR = 2'd2;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_BAD_SIZE = 2'd1;
    localparam logic [1:0] STATUS_OUTSIDE  = 2'd2;

    localparam logic [1:0] REG_CANVAS_WIDTH    = 2'd0;
    localparam logic [1:0] REG_CANVAS_HEIGHT   = 2'd1;
    localparam logic [1:0] REG_BACKGROUND_CODE = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP,
        ST_SCAN,
        ST_READ,
        ST_FINISH
    } state_t;

    // Rectangle edges and the inner edges one unit in from them.
    typedef struct packed {
        logic signed [CMP_W-1:0] left;
        logic signed [CMP_W-1:0] right;
        logic signed [CMP_W-1:0] top;
        logic signed [CMP_W-1:0] bottom;
        logic signed [CMP_W-1:0] left_in;
        logic signed [CMP_W-1:0] right_in;
        logic signed [CMP_W-1:0] top_in;
        logic signed [CMP_W-1:0] bottom_in;
    } bounds_t;

endpackage

FILE: design/rcp_cover.sv
module rcp_cover
    import rcp_pkg::*;
(
    input  bounds_t           bounds,
    input  logic              outline_only,
    input  logic [COL_W-1:0]  column,
    input  logic [ROW_W-1:0]  row,
    output logic              hit
);

    logic signed [CMP_W-1:0] px;
    logic signed [CMP_W-1:0] py;
    logic                    in_rect;
    logic                    near_edge;

    assign px = $signed(CMP_W'({column, 8'd0}));
    assign py = $signed(CMP_W'({row, 8'd0}));

    assign in_rect = (px >= bounds.left) && (px <= bounds.right) &&
                     (py >= bounds.top) && (py <= bounds.bottom);

    assign near_edge = (px < bounds.left_in) || (px > bounds.right_in) ||
                       (py < bounds.top_in) || (py > bounds.bottom_in);

    assign hit = in_rect && (!outline_only || near_edge);

endmodule

FILE: design/rectangle_canvas_painter.sv
// Channel     Direction  Fields
// s_axis      in         tuser: func, outline_only; tdata: rectangle, code, read cell
// m_axis      out        tuser: status; tdata: cell_code
// apb         in         canvas_width, canvas_height, background_code
//
// A valid draw runs six setup steps on the shared adder, then scans one canvas
// cell per cycle; a clear scans without setup; a read fetches one cell; other items go straight to the result.
// The single canvas memory port sets the scan rate of one cell per cycle.
// The canvas memory is not cleared by reset; control state resets asynchronously.
// A finished result waits in the output register while the next item is accepted.
module rectangle_canvas_painter
    import rcp_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,

    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // [23:0] rect_left, [47:24] rect_top, [71:48] rect_width, [95:72] rect_height,
    // [103:96] paint_code, [111:104] read_row, [119:112] read_column
    input  logic [119:0] s_axis_tdata,
    // [1:0] func, [2] outline_only
    input  logic [2:0]   s_axis_tuser,

    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // [7:0] cell_code
    output logic [7:0]   m_axis_tdata,
    // [1:0] status
    output logic [1:0]   m_axis_tuser,

    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [3:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    logic [8:0]  canvas_width_reg;
    logic [8:0]  canvas_height_reg;
    logic [7:0]  background_code_reg;

    state_t      state_reg, state_next;
    logic [2:0]  step_reg, step_next;
    logic [COL_W-1:0] x_reg, x_next;
    logic [ROW_W-1:0] y_reg, y_next;
    logic [1:0]  status_reg, status_next;

    logic [1:0]  func_reg;
    logic        outline_reg;
    logic signed [FIX_W-1:0] left_reg, top_reg, width_reg, height_reg;
    logic [7:0]  code_reg;
    logic [COL_W-1:0] rd_col_reg;
    logic [ROW_W-1:0] rd_row_reg;
    logic [7:0]  rd_data_reg;
    bounds_t     bounds_reg;

    logic        out_valid_reg;
    logic [1:0]  out_status_reg;
    logic [7:0]  out_code_reg;

    logic [7:0]  canvas_mem [MAX_HEIGHT][MAX_WIDTH];

    logic [1:0]  in_func;
    logic        in_outline;
    logic signed [FIX_W-1:0] in_width, in_height;
    logic [7:0]  in_row, in_col;
    logic [IDX_W-1:0] eff_w, eff_h;
    logic        canvas_empty;
    logic        accept;
    logic        out_free;
    logic        finish;
    logic        last_x, last_y;
    logic        hit;
    logic        paint;
    logic        cfg_write;
    logic signed [CMP_W-1:0] add_a, add_b, add_sum;

    assign in_func    = s_axis_tuser[1:0];
    assign in_outline = s_axis_tuser[2];
    assign in_width   = s_axis_tdata[71:48];
    assign in_height  = s_axis_tdata[95:72];
    assign in_row     = s_axis_tdata[111:104];
    assign in_col     = s_axis_tdata[119:112];

    assign eff_w = (IDX_W'(canvas_width_reg) > IDX_W'(MAX_WIDTH)) ?
                   IDX_W'(MAX_WIDTH) : IDX_W'(canvas_width_reg);
    assign eff_h = (IDX_W'(canvas_height_reg) > IDX_W'(MAX_HEIGHT)) ?
                   IDX_W'(MAX_HEIGHT) : IDX_W'(canvas_height_reg);
    assign canvas_empty = (eff_w == '0) || (eff_h == '0);

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign accept   = s_axis_tvalid && s_axis_tready;
    assign out_free = !out_valid_reg || m_axis_tready;
    assign finish   = (state_reg == ST_FINISH) && out_free;

    assign last_x = (IDX_W'(x_reg) == eff_w - IDX_W'(1));
    assign last_y = (IDX_W'(y_reg) == eff_h - IDX_W'(1));

    rcp_cover u_cover (
        .bounds       (bounds_reg),
        .outline_only (outline_reg),
        .column       (x_reg),
        .row          (y_reg),
        .hit          (hit)
    );

    assign paint = (state_reg == ST_SCAN) && ((func_reg == FUNC_CLEAR) || hit);

    // Shared adder for the edge setup steps.
    always_comb
    begin
        case (step_reg)
            3'd0:
            begin
                add_a = CMP_W'(left_reg);
                add_b = CMP_W'(width_reg);
            end
            3'd1:
            begin
                add_a = CMP_W'(top_reg);
                add_b = CMP_W'(height_reg);
            end
            3'd2:
            begin
                add_a = bounds_reg.left;
                add_b = ONE_UNIT;
            end
            3'd3:
            begin
                add_a = bounds_reg.right;
                add_b = -ONE_UNIT;
            end
            3'd4:
            begin
                add_a = bounds_reg.top;
                add_b = ONE_UNIT;
            end
            default:
            begin
                add_a = bounds_reg.bottom;
                add_b = -ONE_UNIT;
            end
        endcase
    end

    assign add_sum = add_a + add_b;

    always_comb
    begin
        state_next  = state_reg;
        step_next   = step_reg;
        x_next      = x_reg;
        y_next      = y_reg;
        status_next = status_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    status_next = STATUS_OK;
                    step_next   = '0;
                    x_next      = '0;
                    y_next      = '0;
                    state_next  = ST_FINISH;
                    case (in_func)
                        FUNC_DRAW:
                        begin
                            if ((in_width <= FIX_W'(0)) || (in_height <= FIX_W'(0)))
                            begin
                                status_next = STATUS_BAD_SIZE;
                            end
                            else if (!canvas_empty)
                            begin
                                state_next = ST_SETUP;
                            end
                        end
                        FUNC_READ:
                        begin
                            if ((IDX_W'(in_row) >= eff_h) || (IDX_W'(in_col) >= eff_w))
                            begin
                                status_next = STATUS_OUTSIDE;
                            end
                            else
                            begin
                                state_next = ST_READ;
                            end
                        end
                        FUNC_CLEAR:
                        begin
                            if (!canvas_empty)
                            begin
                                state_next = ST_SCAN;
                            end
                        end
                        default:
                        begin
                            state_next = ST_FINISH;
                        end
                    endcase
                end
            end
            ST_SETUP:
            begin
                step_next = step_reg + 3'd1;
                if (step_reg == 3'd5)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (last_x)
                begin
                    x_next = '0;
                    if (last_y)
                    begin
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        y_next = y_reg + ROW_W'(1);
                    end
                end
                else
                begin
                    x_next = x_reg + COL_W'(1);
                end
            end
            ST_READ:
            begin
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            x_reg         <= '0;
            y_reg         <= '0;
            status_reg    <= STATUS_OK;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            step_reg   <= step_next;
            x_reg      <= x_next;
            y_reg      <= y_next;
            status_reg <= status_next;
            if (finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            func_reg    <= in_func;
            outline_reg <= in_outline;
            left_reg    <= s_axis_tdata[23:0];
            top_reg     <= s_axis_tdata[47:24];
            width_reg   <= in_width;
            height_reg  <= in_height;
            code_reg    <= s_axis_tdata[103:96];
            rd_row_reg  <= ROW_W'(IDX_W'(in_row));
            rd_col_reg  <= COL_W'(IDX_W'(in_col));
        end
        if (state_reg == ST_SETUP)
        begin
            case (step_reg)
                3'd0:    bounds_reg.right     <= add_sum;
                3'd1:    bounds_reg.bottom    <= add_sum;
                3'd2:    bounds_reg.left_in   <= add_sum;
                3'd3:    bounds_reg.right_in  <= add_sum;
                3'd4:    bounds_reg.top_in    <= add_sum;
                default: bounds_reg.bottom_in <= add_sum;
            endcase
            bounds_reg.left <= CMP_W'(left_reg);
            bounds_reg.top  <= CMP_W'(top_reg);
        end
        if (finish)
        begin
            out_status_reg <= status_reg;
            out_code_reg   <= ((func_reg == FUNC_READ) && (status_reg == STATUS_OK)) ?
                              rd_data_reg : 8'd0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (paint)
        begin
            canvas_mem[y_reg][x_reg] <= (func_reg == FUNC_CLEAR) ?
                                        background_code_reg : code_reg;
        end
        if (state_reg == ST_READ)
        begin
            rd_data_reg <= canvas_mem[rd_row_reg][rd_col_reg];
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_code_reg;
    assign m_axis_tuser  = out_status_reg;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            canvas_width_reg    <= 9'd256;
            canvas_height_reg   <= 9'd256;
            background_code_reg <= 8'd32;
        end
        else if (cfg_write)
        begin
            case (paddr[3:2])
                REG_CANVAS_WIDTH:    canvas_width_reg    <= pwdata[8:0];
                REG_CANVAS_HEIGHT:   canvas_height_reg   <= pwdata[8:0];
                REG_BACKGROUND_CODE: background_code_reg <= pwdata[7:0];
                default:             ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_CANVAS_WIDTH:    prdata = 32'(canvas_width_reg);
            REG_CANVAS_HEIGHT:   prdata = 32'(canvas_height_reg);
            REG_BACKGROUND_CODE: prdata = 32'(background_code_reg);
            default:             prdata = 32'd0;
        endcase
    end

endmodule

FILE: tb/testbench.sv
module testbench;
    import rcp_pkg::*;

    localparam logic [1:0] FUNC_UNUSED = 2'd3;
    localparam logic [7:0] CODE_UPPER_R = "R";
    localparam logic [7:0] CODE_LOWER_R = "r";
    localparam int WATCHDOG_LIMIT = 300000;
    localparam int HOLD_AT_RESULT = 55;
    localparam int HOLD_CYCLES = 400;
    localparam int ITEMS_PER_PHASE = 13;
    localparam int SMALL_START = 9;
    localparam int DIRECTED_ROWS = 25;
    localparam int PHASES = 8;
    localparam int CELLS = MAX_WIDTH * MAX_HEIGHT;

    typedef struct {
        logic [1:0]         func;
        logic               outline;
        logic signed [23:0] left;
        logic signed [23:0] top;
        logic signed [23:0] wid;
        logic signed [23:0] hgt;
        logic [7:0]         code;
        logic [7:0]         row;
        logic [7:0]         col;
    } paint_cmd_t;

    typedef struct {
        paint_cmd_t cmd;
        bit         known;
        logic [1:0] status;
        logic [7:0] cell_code;
    } directed_row_t;

    typedef struct {
        logic [1:0] status;
        logic [7:0] cell_code;
    } answer_t;

    typedef struct {
        logic [8:0] cols;
        logic [8:0] rows;
        logic [7:0] bg;
    } canvas_setting_t;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [119:0] s_axis_tdata = '0;
    logic [2:0]   s_axis_tuser = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [7:0]   m_axis_tdata;
    logic [1:0]   m_axis_tuser;
    logic         psel = 1'b0;
    logic         penable = 1'b0;
    logic         pwrite = 1'b0;
    logic [3:0]   paddr = '0;
    logic [31:0]  pwdata = '0;
    logic [31:0]  prdata;
    logic         pready;

    logic [7:0] canvas_mem [CELLS];
    bit         cell_written [CELLS];
    int         cfg_cols = MAX_WIDTH;
    int         cfg_rows = MAX_HEIGHT;
    logic [7:0] cfg_bg = 8'd32;
    answer_t    answers_due [$];
    int         error_count = 0;
    int         results_seen = 0;
    int         sender_calm = 0;

    directed_row_t directed_rows [DIRECTED_ROWS] = '{
        '{'{FUNC_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0}, 1, STATUS_OK, 0},
        '{'{FUNC_READ, 0, 0, 0, 0, 0, 0, 0, 0}, 1, STATUS_OK, 32},
        '{'{FUNC_READ, 1, 0, 0, 0, 0, 255, 255, 255}, 1, STATUS_OK, 32},
        '{'{FUNC_DRAW, 0, 0, 0, 0, 256, 65, 0, 0}, 1, STATUS_BAD_SIZE, 0},
        '{'{FUNC_DRAW, 1, 0, 0, 256, 24'h800000, 65, 0, 0}, 1, STATUS_BAD_SIZE, 0},
        '{'{FUNC_DRAW, 1, -640, -768, 2752, 1664, CODE_UPPER_R, 0, 0}, 0, STATUS_OK, 0},
        '{'{FUNC_READ, 0, 0, 0, 0, 0, 0, 0, 5}, 0, STATUS_OK, 0},
        '{'{FUNC_READ, 0, 0, 0, 0, 0, 0, 3, 3}, 0, STATUS_OK, 0},
        '{'{FUNC_READ, 0, 0, 0, 0, 0, 0, 5, 1}, 0, STATUS_OK, 0},
        '{'{FUNC_CLEAR, 1, 24'h7FFFFF, 0, 0, 0, 255, 0, 0}, 1, STATUS_OK, 0},
        '{'{FUNC_READ, 0, 0, 0, 0, 0, 0, 5, 7}, 1, STATUS_OK, 0},
        '{'{FUNC_READ, 0, 0, 0, 0, 0, 0, 6, 0}, 1, STATUS_OUTSIDE, 0},
        '{'{FUNC_READ, 0, 0, 0, 0, 0, 0, 0, 8}, 1, STATUS_OUTSIDE, 0},
        '{'{FUNC_READ, 0, 0, 0, 0, 0, 0, 255, 255}, 1, STATUS_OUTSIDE, 0},
        '{'{FUNC_DRAW, 0, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 255, 0, 0},
          1, STATUS_OK, 0},
        '{'{FUNC_DRAW, 1, 24'h800000, 24'h800000, 24'h7FFFFF, 24'h7FFFFF, 255, 0, 0},
          1, STATUS_OK, 0},
        '{'{FUNC_DRAW, 0, 128, 128, 832, 512, 255, 0, 0}, 0, STATUS_OK, 0},
        '{'{FUNC_DRAW, 1, 0, 0, 1536, 1024, CODE_LOWER_R, 0, 0}, 0, STATUS_OK, 0},
        '{'{FUNC_READ, 0, 0, 0, 0, 0, 0, 1, 1}, 0, STATUS_OK, 0},
        '{'{FUNC_READ, 0, 0, 0, 0, 0, 0, 2, 3}, 0, STATUS_OK, 0},
        '{'{FUNC_READ, 0, 0, 0, 0, 0, 0, 4, 6}, 0, STATUS_OK, 0},
        '{'{FUNC_UNUSED, 1, 24'h7FFFFF, 24'h800000, 24'h555555, 24'hAAAAAA, 8'hAA,
            8'h55, 8'hAA}, 1, STATUS_OK, 0},
        '{'{FUNC_DRAW, 0, 0, 0, 24'h800000, 24'h7FFFFF, 8'h5A, 0, 0}, 1, STATUS_BAD_SIZE, 0},
        '{'{FUNC_READ, 0, 0, 0, 0, 0, 0, 0, 0}, 0, STATUS_OK, 0},
        '{'{FUNC_READ, 0, 0, 0, 0, 0, 0, 2, 2}, 0, STATUS_OK, 0}
    };

    canvas_setting_t phase_settings [PHASES] = '{
        '{9'd511, 9'd1, 8'hFF},
        '{9'd1, 9'd300, 8'h00},
        '{9'd0, 9'd4, 8'h07},
        '{9'd5, 9'd0, 8'h72},
        '{9'd12, 9'd9, 8'h2E},
        '{9'd16, 9'd16, 8'h52},
        '{9'd3, 9'd2, 8'hA5},
        '{9'd20, 9'd7, 8'h5A}
    };

    rectangle_canvas_painter i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    task automatic paint_and_answer(input paint_cmd_t c, output answer_t ans);
        longint l;
        longint t;
        longint r;
        longint b;
        longint px;
        longint py;
        bit     hit;
        ans.status = STATUS_OK;
        ans.cell_code = 8'd0;
        case (c.func)
            FUNC_DRAW:
            begin
                if (c.wid <= 24'sd0 || c.hgt <= 24'sd0)
                begin
                    ans.status = STATUS_BAD_SIZE;
                end
                else
                begin
                    l = c.left;
                    t = c.top;
                    r = l + c.wid;
                    b = t + c.hgt;
                    for (int y = 0; y < cfg_rows; y++)
                    begin
                        for (int x = 0; x < cfg_cols; x++)
                        begin
                            px = x * ONE_UNIT;
                            py = y * ONE_UNIT;
                            hit = px >= l && px <= r && py >= t && py <= b;
                            if (hit && c.outline)
                            begin
                                hit = (px - l < ONE_UNIT) || (r - px < ONE_UNIT) ||
                                      (py - t < ONE_UNIT) || (b - py < ONE_UNIT);
                            end
                            if (hit)
                            begin
                                canvas_mem[y * MAX_WIDTH + x] = c.code;
                                cell_written[y * MAX_WIDTH + x] = 1'b1;
                            end
                        end
                    end
                end
            end
            FUNC_READ:
            begin
                if (c.row >= cfg_rows || c.col >= cfg_cols)
                begin
                    ans.status = STATUS_OUTSIDE;
                end
                else
                begin
                    ans.cell_code = canvas_mem[c.row * MAX_WIDTH + c.col];
                end
            end
            FUNC_CLEAR:
            begin
                for (int y = 0; y < cfg_rows; y++)
                begin
                    for (int x = 0; x < cfg_cols; x++)
                    begin
                        canvas_mem[y * MAX_WIDTH + x] = cfg_bg;
                        cell_written[y * MAX_WIDTH + x] = 1'b1;
                    end
                end
            end
            default:
            begin
            end
        endcase
    endtask

    // Most draws land near the canvas; reads mostly hit cells that hold a code.
    function automatic paint_cmd_t random_cmd();
        paint_cmd_t c;
        int         pick;
        c.func = FUNC_UNUSED;
        c.outline = 1'($urandom_range(0, 1));
        c.left = 24'($urandom);
        c.top = 24'($urandom);
        c.wid = 24'($urandom);
        c.hgt = 24'($urandom);
        c.code = 8'($urandom);
        c.row = 8'($urandom);
        c.col = 8'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 45)
        begin
            c.func = FUNC_DRAW;
            if (pick >= 6)
            begin
                c.left = 24'($urandom_range(0, (cfg_cols + 6) * 256) - 768);
                c.top = 24'($urandom_range(0, (cfg_rows + 6) * 256) - 768);
                c.wid = 24'($urandom_range(1, (cfg_cols + 4) * 256));
                c.hgt = 24'($urandom_range(1, (cfg_rows + 4) * 256));
                if (pick < 8)
                begin
                    c.wid = 24'(0 - $urandom_range(0, 2000));
                end
                else if (pick < 10)
                begin
                    c.hgt = 24'(0 - $urandom_range(0, 2000));
                end
            end
        end
        else if (pick < 85)
        begin
            c.func = FUNC_READ;
            if (pick < 75 && cfg_cols > 0 && cfg_rows > 0)
            begin
                c.row = 8'($urandom_range(0, cfg_rows - 1));
                c.col = 8'($urandom_range(0, cfg_cols - 1));
            end
        end
        else if (pick < 95)
        begin
            c.func = FUNC_CLEAR;
        end
        if (c.func == FUNC_READ && c.row < cfg_rows && c.col < cfg_cols &&
            !cell_written[c.row * MAX_WIDTH + c.col])
        begin
            c.func = FUNC_CLEAR;
        end
        return c;
    endfunction

    task automatic send_cmd(input paint_cmd_t c, input bit known, input logic [1:0] status,
                            input logic [7:0] cell_code);
        int      gap;
        answer_t calc;
        answer_t typed;
        if (sender_calm > 0)
        begin
            gap = 0;
            sender_calm--;
        end
        else if ($urandom_range(0, 5) == 0)
        begin
            sender_calm = $urandom_range(8, 20);
            gap = 0;
        end
        else
        begin
            gap = $urandom_range(0, 12);
        end
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tdata <= {c.col, c.row, c.code, c.hgt, c.wid, c.top, c.left};
        s_axis_tuser <= {c.outline, c.func};
        s_axis_tvalid <= 1'b1;
        do @(posedge clk); while (!s_axis_tready);
        paint_and_answer(c, calc);
        if (known)
        begin
            typed.status = status;
            typed.cell_code = cell_code;
            answers_due.push_back(typed);
        end
        else
        begin
            answers_due.push_back(calc);
        end
    endtask

    task automatic drain_answers();
        s_axis_tvalid <= 1'b0;
        while (answers_due.size() != 0) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [8:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= 32'(value);
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_CANVAS_WIDTH:    cfg_cols = (value > MAX_WIDTH) ? MAX_WIDTH : int'(value);
            REG_CANVAS_HEIGHT:   cfg_rows = (value > MAX_HEIGHT) ? MAX_HEIGHT : int'(value);
            REG_BACKGROUND_CODE: cfg_bg = value[7:0];
            default:
            begin
            end
        endcase
        @(posedge clk);
    endtask

    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            begin
                quiet = 0;
            end
            else
            begin
                quiet++;
            end
        end
        $display("FAILURE");
        $finish;
    end

    initial
    begin
        int      stall;
        int      calm;
        answer_t due;
        calm = 0;
        @(posedge rst_n);
        forever
        begin
            if (calm > 0)
            begin
                stall = 0;
                calm--;
            end
            else if ($urandom_range(0, 5) == 0)
            begin
                calm = $urandom_range(8, 20);
                stall = 0;
            end
            else
            begin
                stall = $urandom_range(0, 12);
            end
            // A long hold-off lets the block fill up and stall its input.
            if (results_seen == HOLD_AT_RESULT)
            begin
                stall = HOLD_CYCLES;
            end
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge clk); while (!m_axis_tvalid);
            results_seen++;
            if (answers_due.size() == 0)
            begin
                $error("unexpected transfer: status %0d, cell_code %0d",
                       m_axis_tuser, m_axis_tdata);
                error_count++;
            end
            else
            begin
                due = answers_due.pop_front();
                if (m_axis_tuser !== due.status)
                begin
                    $error("status: expected %0d, actual %0d", due.status, m_axis_tuser);
                    error_count++;
                end
                if (m_axis_tdata !== due.cell_code)
                begin
                    $error("cell_code: expected %0d, actual %0d", due.cell_code,
                           m_axis_tdata);
                    error_count++;
                end
            end
        end
    end

    initial
    begin
        paint_cmd_t clear_cmd;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        for (int i = 0; i < DIRECTED_ROWS; i++)
        begin
            if (i == SMALL_START)
            begin
                drain_answers();
                write_reg(REG_CANVAS_WIDTH, 9'd8);
                write_reg(REG_CANVAS_HEIGHT, 9'd6);
                write_reg(REG_BACKGROUND_CODE, 9'd0);
            end
            send_cmd(directed_rows[i].cmd, directed_rows[i].known, directed_rows[i].status,
                     directed_rows[i].cell_code);
        end
        for (int p = 0; p < PHASES; p++)
        begin
            drain_answers();
            write_reg(REG_CANVAS_WIDTH, phase_settings[p].cols);
            write_reg(REG_CANVAS_HEIGHT, phase_settings[p].rows);
            write_reg(REG_BACKGROUND_CODE, {1'b0, phase_settings[p].bg});
            clear_cmd = random_cmd();
            clear_cmd.func = FUNC_CLEAR;
            send_cmd(clear_cmd, 1'b0, STATUS_OK, 8'd0);
            for (int k = 0; k < ITEMS_PER_PHASE; k++)
            begin
                send_cmd(random_cmd(), 1'b0, STATUS_OK, 8'd0);
            end
        end
        drain_answers();
        repeat (20) @(posedge clk);
        if (error_count == 0)
        begin
            $display("SUCCESS");
        end
        else
        begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
